@@ rtl/core/fcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg: shared constants and types
// Widths, register indexes, reset values and serial unit opcodes for the
// freeze crossfade controller.
// ----------------------------------------------------------------------------
package fcc_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 17;
  localparam int FADE_W     = 18;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int MACC_W     = 42;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int DEF_CAPTURE_DEPTH = 524288;
  localparam int DEF_CURVE_ENTRIES = 1024;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_XFADE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPSIZE = 2'd2;

  localparam logic [FADE_W-1:0] RST_XFADE   = 18'd1323;
  localparam logic [CFG_W-1:0]  RST_HOLD    = 20'd44100;
  localparam logic [CFG_W-1:0]  RST_CAPSIZE = 20'd441000;

  // serial unit opcodes
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } fcc_ctl_t;

endpackage

@@ rtl/core/fcc_serial.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_serial: shared bit-serial multiply / divide unit
// MUL: acc = den * num[GAIN_W-1:0], one multiplier bit per cycle, MSB first.
// DIV: restoring divide, one quotient bit per cycle; sh = quotient, acc = rem.
// ----------------------------------------------------------------------------
module fcc_serial #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fcc_pkg::fcc_ctl_t             ctl,
  input  logic [NUM_W-1:0]              num,
  input  logic [DEN_W-1:0]              den,
  output logic                          done,
  output logic [DEN_W+fcc_pkg::GAIN_W-1:0] acc,
  output logic [NUM_W-1:0]              quot
);
  import fcc_pkg::*;

  localparam int ACC_W = DEN_W + GAIN_W;
  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic             op_r;
  logic [ACC_W-1:0] acc_r;
  logic [NUM_W-1:0] sh_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] trial;

  assign rem_sh = {acc_r[DEN_W-1:0], sh_r[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end else if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (ctl.op == OP_MUL) ? CNT_W'(GAIN_W - 1) : CNT_W'(NUM_W - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && ctl.start) begin
      acc_r <= '0;
      sh_r  <= num;
      den_r <= den;
      op_r  <= ctl.op;
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        acc_r <= (acc_r << 1) + (sh_r[GAIN_W-1] ? ACC_W'(den_r) : '0);
        sh_r  <= sh_r << 1;
      end else begin
        if (!trial[DEN_W+1]) begin
          acc_r <= ACC_W'(trial[DEN_W-1:0]);
          sh_r  <= {sh_r[NUM_W-2:0], 1'b1};
        end else begin
          acc_r <= ACC_W'(rem_sh);
          sh_r  <= {sh_r[NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign quot = sh_r;

endmodule

@@ rtl/core/freeze_crossfade_controller.sv @@
`timescale 1ns / 1ps
// Sequencing: the mix lanes run beside the shared serial unit, which adds a
//   capture-pointer divide with a capture write, and a snapshot divide, a
//   fade-length multiply, a curve index divide and a step multiply when a
//   snapshot and a curve step stack.
// Throughput: one beat at a time; the next beat is taken once the result is
//   registered, while that result may still wait on out_stall.
// Reset: synchronous active-low; fade state, ring pointers and region clear.
// ----------------------------------------------------------------------------
// freeze_crossfade_controller: raised-cosine freeze crossfade
// Mixes dry and wet stereo by a wet gain that fades along a sin^2 curve when
// the freeze request toggles, snapshots the frozen region from the capture
// ring when freezing from fully live, and writes dry frames to the ring.
// ----------------------------------------------------------------------------
module freeze_crossfade_controller #(
  parameter int CAPTURE_DEPTH = fcc_pkg::DEF_CAPTURE_DEPTH,
  parameter int CURVE_ENTRIES = fcc_pkg::DEF_CURVE_ENTRIES
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input beat
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [fcc_pkg::SAMPLE_W-1:0]     in_dry_left,
  input  logic signed [fcc_pkg::SAMPLE_W-1:0]     in_dry_right,
  input  logic signed [fcc_pkg::SAMPLE_W-1:0]     in_wet_left,
  input  logic signed [fcc_pkg::SAMPLE_W-1:0]     in_wet_right,
  input  logic                                    in_freeze_request,
  // result beat
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [fcc_pkg::SAMPLE_W-1:0]     out_mix_left,
  output logic signed [fcc_pkg::SAMPLE_W-1:0]     out_mix_right,
  output logic signed [fcc_pkg::SAMPLE_W-1:0]     out_mono_sum,
  output logic                                    out_capture_write,
  output logic [$clog2(CAPTURE_DEPTH)-1:0]        out_capture_address,
  output logic [$clog2(CAPTURE_DEPTH)-1:0]        out_region_start,
  output logic [$clog2(CAPTURE_DEPTH+1)-1:0]      out_region_length,
  output logic                                    out_grain_reset,
  output logic                                    out_render_enable,
  // config writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [fcc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [fcc_pkg::CFG_W-1:0]               cfg_data
);
  import fcc_pkg::*;

  localparam int PTR_W  = $clog2(CAPTURE_DEPTH);
  localparam int CAP_W  = $clog2(CAPTURE_DEPTH + 1);
  localparam int CIDX_W = $clog2(CURVE_ENTRIES);
  localparam int ENT_W  = $clog2(CURVE_ENTRIES + 1);
  localparam int WIDE_W = (CAP_W > CFG_W) ? CAP_W : CFG_W;
  localparam int NUM_A  = FADE_W + ENT_W;
  localparam int NUM_B  = $clog2(3 * CAPTURE_DEPTH);
  localparam int NUM_W  = (NUM_A > NUM_B) ? NUM_A : NUM_B;
  localparam int DEN_W  = (FADE_W > CAP_W) ? FADE_W : CAP_W;
  localparam int ACC_W  = DEN_W + GAIN_W;
  localparam int MCNT_W = $clog2(GAIN_W);

  localparam logic signed [MACC_W-1:0] MIX_HI = MACC_W'(8388607);
  localparam logic signed [MACC_W-1:0] MIX_LO = -MACC_W'(8388608);

  // sequencer codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECIDE = 4'd1;
  localparam logic [3:0] ST_SNAP   = 4'd2;
  localparam logic [3:0] ST_FLEN   = 4'd3;
  localparam logic [3:0] ST_ADV    = 4'd4;
  localparam logic [3:0] ST_IDX    = 4'd5;
  localparam logic [3:0] ST_ROM    = 4'd6;
  localparam logic [3:0] ST_STEP   = 4'd7;
  localparam logic [3:0] ST_CAPT   = 4'd8;
  localparam logic [3:0] ST_WRAP   = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  // --------------------------------------------------------------------------
  // sin^2 curve ROM, built at elaboration with the Q30 Taylor polynomial
  // --------------------------------------------------------------------------
  typedef logic [15:0] curve_rom_t [CURVE_ENTRIES];

  function automatic curve_rom_t build_curve();
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] b;
    logic [63:0] s;
    logic [63:0] c;
    curve_rom_t  rom;
    for (int k = 0; k < CURVE_ENTRIES; k++) begin
      th = (HALF_PI_Q30 * 64'(k)) / CURVE_ENTRIES;
      t2 = (th * th) >> 30;
      b  = Q30_ONE - t2 / 110;
      b  = Q30_ONE - ((t2 * b) >> 30) / 72;
      b  = Q30_ONE - ((t2 * b) >> 30) / 42;
      b  = Q30_ONE - ((t2 * b) >> 30) / 20;
      b  = Q30_ONE - ((t2 * b) >> 30) / 6;
      s  = (th * b) >> 30;
      c  = (((s * s) >> 30) + 64'd8192) >> 14;
      rom[k] = (c > 64'd65535) ? 16'hFFFF : c[15:0];
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve();

  function automatic logic signed [SAMPLE_W-1:0] sat_mix(input logic signed [MACC_W-1:0] v);
    logic signed [MACC_W-1:0] q;
    q = v >>> 16;
    if (q > MIX_HI)      sat_mix = MIX_HI[SAMPLE_W-1:0];
    else if (q < MIX_LO) sat_mix = MIX_LO[SAMPLE_W-1:0];
    else                 sat_mix = q[SAMPLE_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic [FADE_W-1:0] xfade_r;
  logic [CFG_W-1:0]  hold_r;
  logic [CFG_W-1:0]  capsize_r;

  logic [GAIN_W-1:0] gain_r;
  logic [GAIN_W-1:0] start_gain_r;
  logic              target_r;
  logic [FADE_W-1:0] flen_r;
  logic [FADE_W-1:0] fpos_r;
  logic              active_r;
  logic              goal_r;
  logic [PTR_W-1:0]  wp_r;
  logic [CAP_W-1:0]  filled_r;
  logic [PTR_W-1:0]  fstart_r;
  logic [CAP_W-1:0]  frlen_r;

  logic [3:0]        state_r, state_nxt;

  // beat payload
  logic signed [SAMPLE_W-1:0] dl_r, dr_r, wl_r, wr_r;
  logic                       req_r;
  logic                       pulse_r;
  logic                       render_r;
  logic                       capwr_r;
  logic [PTR_W-1:0]           capaddr_r;
  logic [15:0]                rom_q_r;

  // mix lanes, one gain bit per cycle, LSB first
  logic signed [MACC_W-1:0] macc_l_r, macc_r_r;
  logic signed [MACC_W-1:0] diff_l_r, diff_r_r;
  logic [GAIN_W-1:0]        gsh_r;
  logic [MCNT_W-1:0]        mcnt_r;
  logic                     mix_busy_r;

  // result register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] o_ml_r, o_mr_r, o_mono_r;
  logic                       o_capwr_r;
  logic [PTR_W-1:0]           o_capaddr_r;
  logic [PTR_W-1:0]           o_rstart_r;
  logic [CAP_W-1:0]           o_rlen_r;
  logic                       o_pulse_r;
  logic                       o_render_r;

  // --------------------------------------------------------------------------
  // serial unit
  // --------------------------------------------------------------------------
  fcc_ctl_t          u_ctl;
  logic [NUM_W-1:0]  u_num;
  logic [DEN_W-1:0]  u_den;
  logic              u_done;
  logic [ACC_W-1:0]  u_acc;
  logic [NUM_W-1:0]  u_quot;

  fcc_serial #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (u_ctl),
    .num   (u_num),
    .den   (u_den),
    .done  (u_done),
    .acc   (u_acc),
    .quot  (u_quot)
  );

  // --------------------------------------------------------------------------
  // step decisions
  // --------------------------------------------------------------------------
  logic [WIDE_W-1:0] cs_wide, hold_wide, cap_wide;
  logic [CAP_W-1:0]  cap;
  logic [CAP_W-1:0]  fill;
  logic [CAP_W-1:0]  held;
  logic              live;
  logic              change;
  logic              snap;
  logic [FADE_W-1:0] full;
  logic [GAIN_W-1:0] gain_dist;
  logic [FADE_W-1:0] pos_inc;
  logic              use_curve;
  logic [GAIN_W-1:0] step_d;
  logic [NUM_W-1:0]  mod_num;
  logic [ACC_W-1:0]  rnd;
  logic [FADE_W-1:0] len_raw;
  logic [GAIN_W:0]   gain_sum;
  logic [CAP_W:0]    fill_inc;
  logic              out_free;
  logic signed [SAMPLE_W-1:0] mix_l, mix_r;
  logic signed [SAMPLE_W:0]   mono_full;

  always_comb begin
    cs_wide = WIDE_W'(capsize_r);
    if (cs_wide == '0)                          cap_wide = WIDE_W'(1);
    else if (cs_wide > WIDE_W'(CAPTURE_DEPTH))  cap_wide = WIDE_W'(CAPTURE_DEPTH);
    else                                        cap_wide = cs_wide;
    cap  = cap_wide[CAP_W-1:0];
    fill = (filled_r < cap) ? filled_r : cap;

    hold_wide = (hold_r == '0) ? WIDE_W'(1) : WIDE_W'(hold_r);
    held = (hold_wide > WIDE_W'(fill)) ? fill : hold_wide[CAP_W-1:0];

    live   = !goal_r && !active_r && (gain_r == '0);
    change = req_r != goal_r;
    snap   = change && req_r && live;

    full      = (xfade_r == '0) ? FADE_W'(1) : xfade_r;
    gain_dist = req_r ? (GAIN_ONE - gain_r) : gain_r;

    pos_inc   = fpos_r + 1'b1;
    use_curve = (flen_r > FADE_W'(1)) && (pos_inc < flen_r - 1'b1);
    step_d    = target_r ? (GAIN_ONE - start_gain_r) : start_gain_r;

    // frozen start = (wp + 2*cap - held) mod cap
    mod_num = NUM_W'(wp_r) + (NUM_W'(cap) << 1) - NUM_W'(held);

    rnd      = u_acc + ACC_W'(32768);
    len_raw  = rnd[16+FADE_W-1:16];
    gain_sum = target_r ? ({1'b0, start_gain_r} + {1'b0, rnd[16+GAIN_W-1:16]})
                        : ({1'b0, start_gain_r} - {1'b0, rnd[16+GAIN_W-1:16]});
    fill_inc = {1'b0, filled_r} + 1'b1;

    out_free  = !out_valid_r || !out_stall;
    mix_l     = sat_mix(macc_l_r);
    mix_r     = sat_mix(macc_r_r);
    mono_full = {mix_l[SAMPLE_W-1], mix_l} + {mix_r[SAMPLE_W-1], mix_r};
  end

  // --------------------------------------------------------------------------
  // sequencer and serial unit launch
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    u_ctl     = '{start: 1'b0, op: OP_MUL};
    u_num     = '0;
    u_den     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (snap && fill != '0) begin
          u_ctl     = '{start: 1'b1, op: OP_DIV};
          u_num     = mod_num;
          u_den     = DEN_W'(cap);
          state_nxt = ST_SNAP;
        end else if (change) begin
          u_ctl     = '{start: 1'b1, op: OP_MUL};
          u_num     = NUM_W'(gain_dist);
          u_den     = DEN_W'(full);
          state_nxt = ST_FLEN;
        end else begin
          state_nxt = ST_ADV;
        end
      end
      ST_SNAP: begin
        if (u_done) begin
          u_ctl     = '{start: 1'b1, op: OP_MUL};
          u_num     = NUM_W'(gain_dist);
          u_den     = DEN_W'(full);
          state_nxt = ST_FLEN;
        end
      end
      ST_FLEN: begin
        if (u_done) state_nxt = ST_ADV;
      end
      ST_ADV: begin
        if (active_r && use_curve) begin
          u_ctl     = '{start: 1'b1, op: OP_DIV};
          u_num     = NUM_W'(pos_inc) * NUM_W'(CURVE_ENTRIES);
          u_den     = DEN_W'(flen_r - 1'b1);
          state_nxt = ST_IDX;
        end else begin
          state_nxt = ST_CAPT;
        end
      end
      ST_IDX: begin
        if (u_done) state_nxt = ST_ROM;
      end
      ST_ROM: begin
        u_ctl     = '{start: 1'b1, op: OP_MUL};
        u_num     = NUM_W'(rom_q_r);
        u_den     = DEN_W'(step_d);
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (u_done) state_nxt = ST_CAPT;
      end
      ST_CAPT: begin
        if (live) begin
          u_ctl     = '{start: 1'b1, op: OP_DIV};
          u_num     = NUM_W'(wp_r) + NUM_W'(1);
          u_den     = DEN_W'(cap);
          state_nxt = ST_WRAP;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_WRAP: begin
        if (u_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!mix_busy_r && out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and fade / ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      xfade_r      <= RST_XFADE;
      hold_r       <= RST_HOLD;
      capsize_r    <= RST_CAPSIZE;
      gain_r       <= '0;
      start_gain_r <= '0;
      target_r     <= 1'b0;
      flen_r       <= '0;
      fpos_r       <= '0;
      active_r     <= 1'b0;
      goal_r       <= 1'b0;
      wp_r         <= '0;
      filled_r     <= '0;
      fstart_r     <= '0;
      frlen_r      <= '0;
      mix_busy_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_XFADE:   xfade_r   <= cfg_data[FADE_W-1:0];
          REG_HOLD:    hold_r    <= cfg_data;
          REG_CAPSIZE: capsize_r <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == ST_DECIDE) begin
        mix_busy_r <= 1'b1;
        // empty ring: region collapses
        if (snap && fill == '0) begin
          fstart_r <= '0;
          frlen_r  <= '0;
        end
      end else if (mix_busy_r && mcnt_r == '0) begin
        mix_busy_r <= 1'b0;
      end

      if (state_r == ST_SNAP && u_done) begin
        fstart_r <= u_acc[PTR_W-1:0];
        frlen_r  <= held;
      end

      if (state_r == ST_FLEN && u_done) begin
        start_gain_r <= gain_r;
        target_r     <= req_r;
        fpos_r       <= '0;
        flen_r       <= (len_raw == '0) ? FADE_W'(1) : len_raw;
        active_r     <= 1'b1;
        goal_r       <= req_r;
      end

      if (state_r == ST_ADV && active_r) begin
        fpos_r <= pos_inc;
        if (!use_curve) begin
          // fade end: land on the target exactly
          gain_r   <= target_r ? GAIN_ONE : '0;
          active_r <= 1'b0;
          if (!target_r) begin
            fstart_r <= '0;
            frlen_r  <= '0;
          end
        end
      end

      if (state_r == ST_STEP && u_done) begin
        gain_r <= (gain_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE : gain_sum[GAIN_W-1:0];
      end

      if (state_r == ST_CAPT && live) begin
        filled_r <= (fill_inc < {1'b0, cap}) ? fill_inc[CAP_W-1:0] : cap;
      end

      if (state_r == ST_WRAP && u_done) begin
        wp_r <= u_acc[PTR_W-1:0];
      end

      if (state_r == ST_OUT && !mix_busy_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // beat payload, mix lanes, curve ROM, result register
  always_ff @(posedge clk) begin
    rom_q_r <= CURVE_ROM[u_quot[CIDX_W-1:0]];

    if (state_r == ST_IDLE && in_valid) begin
      dl_r  <= in_dry_left;
      dr_r  <= in_dry_right;
      wl_r  <= in_wet_left;
      wr_r  <= in_wet_right;
      req_r <= in_freeze_request;
    end

    if (state_r == ST_DECIDE) begin
      pulse_r   <= snap;
      capwr_r   <= 1'b0;
      capaddr_r <= '0;
      // acc = dry*65536 + 32768 + (wet - dry) * gain
      macc_l_r  <= (MACC_W'(dl_r) <<< 16) + MACC_W'(32768);
      macc_r_r  <= (MACC_W'(dr_r) <<< 16) + MACC_W'(32768);
      diff_l_r  <= MACC_W'(wl_r) - MACC_W'(dl_r);
      diff_r_r  <= MACC_W'(wr_r) - MACC_W'(dr_r);
      gsh_r     <= gain_r;
      mcnt_r    <= MCNT_W'(GAIN_W - 1);
    end else if (mix_busy_r) begin
      if (gsh_r[0]) begin
        macc_l_r <= macc_l_r + diff_l_r;
        macc_r_r <= macc_r_r + diff_r_r;
      end
      diff_l_r <= diff_l_r <<< 1;
      diff_r_r <= diff_r_r <<< 1;
      gsh_r    <= gsh_r >> 1;
      mcnt_r   <= mcnt_r - 1'b1;
    end

    if (state_r == ST_ADV) begin
      render_r <= goal_r || active_r || (gain_r != '0);
      if (active_r && !use_curve && !target_r) pulse_r <= 1'b1;
    end

    if (state_r == ST_CAPT && live) begin
      capwr_r   <= 1'b1;
      capaddr_r <= wp_r;
    end

    if (state_r == ST_OUT && !mix_busy_r && out_free) begin
      o_ml_r      <= mix_l;
      o_mr_r      <= mix_r;
      o_mono_r    <= mono_full[SAMPLE_W:1];
      o_capwr_r   <= capwr_r;
      o_capaddr_r <= capaddr_r;
      o_rstart_r  <= fstart_r;
      o_rlen_r    <= frlen_r;
      o_pulse_r   <= pulse_r;
      o_render_r  <= render_r;
    end
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_mix_left        = o_ml_r;
  assign out_mix_right       = o_mr_r;
  assign out_mono_sum        = o_mono_r;
  assign out_capture_write   = o_capwr_r;
  assign out_capture_address = o_capaddr_r;
  assign out_region_start    = o_rstart_r;
  assign out_region_length   = o_rlen_r;
  assign out_grain_reset     = o_pulse_r;
  assign out_render_enable   = o_render_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= GAIN_ONE)
    else $error("wet gain above unity");

  a_fade_len: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> flen_r != '0)
    else $error("running fade with zero length");

  a_capaddr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_capture_write) |-> out_capture_address == '0)
    else $error("capture address set without a capture write");

  a_live_no_region: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_capture_write) |-> out_region_length == '0)
    else $error("capturing while a frozen region is held");

endmodule

@@ tb/sv/tb_freeze_crossfade_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_freeze_crossfade_controller: self-checking bench for the freeze crossfade
// Drives stereo frames with freeze toggles through several register settings,
// predicts every mixed frame in a local fixed-point model, and compares each
// result beat field by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_freeze_crossfade_controller;
  import fcc_pkg::*;

  localparam int DEPTH   = DEF_CAPTURE_DEPTH;
  localparam int ENTRIES = DEF_CURVE_ENTRIES;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LEN_W   = $clog2(DEPTH + 1);

  typedef struct {
    logic signed [SAMPLE_W-1:0] dry_l, dry_r, wet_l, wet_r;
    logic                       freeze;
  } frame_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] mix_l, mix_r, mono;
    logic                       cap_wr;
    logic [ADDR_W-1:0]          cap_addr;
    logic [ADDR_W-1:0]          reg_start;
    logic [LEN_W-1:0]           reg_len;
    logic                       grain_rst;
    logic                       render;
  } mix_t;

  // --------------------------------------------------------------------------
  // Crossfade predictor and store of pending mixes
  // --------------------------------------------------------------------------
  class freeze_scoreboard;
    int unsigned xfade, hold, capsize;
    int unsigned gain, start_gain, target, flen, fpos, factive, goal;
    int unsigned wptr, filled, fstart, flength;
    int unsigned curve [ENTRIES];
    mix_t        pending [$];
    int          fail_count, checked, snapshots, releases, wraps;

    function new();
      longint unsigned th, t2, b, s, c;
      for (int k = 0; k < ENTRIES; k++) begin
        th = HALF_PI_Q30 * k / ENTRIES;
        t2 = (th * th) >> 30;
        b  = Q30_ONE - t2 / 110;
        b  = Q30_ONE - ((t2 * b) >> 30) / 72;
        b  = Q30_ONE - ((t2 * b) >> 30) / 42;
        b  = Q30_ONE - ((t2 * b) >> 30) / 20;
        b  = Q30_ONE - ((t2 * b) >> 30) / 6;
        s  = (th * b) >> 30;
        c  = (((s * s) >> 30) + 8192) >> 14;
        curve[k] = (c > 65535) ? 65535 : 32'(c);
      end
      xfade = RST_XFADE; hold = RST_HOLD; capsize = RST_CAPSIZE;
      {gain, start_gain, target, flen, fpos, factive, goal} = '0;
      {wptr, filled, fstart, flength} = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_XFADE:   xfade   = val[FADE_W-1:0];
        REG_HOLD:    hold    = val;
        REG_CAPSIZE: capsize = val;
        default: ;
      endcase
    endfunction

    function int unsigned ring_cap();
      if (capsize == 0) return 1;
      if (capsize > DEPTH) return DEPTH;
      return capsize;
    endfunction

    function bit live();
      return goal == 0 && factive == 0 && gain == 0;
    endfunction

    function longint mix_one(longint d, longint w);
      longint v;
      v = (d * (65536 - longint'(gain)) + w * longint'(gain) + 32768) >>> 16;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v;
    endfunction

    function void note_frame(frame_t f);
      mix_t            m;
      int unsigned     cap, fill, held, goal_gain, gain_dist, full, idx, cv, step;
      longint          ml, mr;
      longint unsigned len;
      m = '{default: '0};
      if (f.freeze != goal) begin
        if (f.freeze && live()) begin
          cap  = ring_cap();
          fill = (filled < cap) ? filled : cap;
          if (fill == 0) begin
            fstart = 0; flength = 0;
          end else begin
            held = (hold == 0) ? 1 : hold;
            if (held > fill) held = fill;
            fstart  = 32'((longint'(wptr) + 2 * longint'(cap) - held) % cap);
            flength = held;
          end
          m.grain_rst = 1;
          snapshots++;
        end
        full       = (xfade == 0) ? 1 : xfade;
        goal_gain  = f.freeze ? 65536 : 0;
        gain_dist  = (goal_gain > gain) ? goal_gain - gain : gain - goal_gain;
        len        = (longint'(full) * gain_dist + 32768) >> 16;
        start_gain = gain;
        target     = 32'(f.freeze);
        fpos       = 0;
        flen       = (len == 0) ? 1 : 32'(len);
        factive    = 1;
        goal       = 32'(f.freeze);
      end
      m.render = goal != 0 || factive != 0 || gain > 0;
      ml = mix_one(f.dry_l, f.wet_l);
      mr = mix_one(f.dry_r, f.wet_r);
      m.mix_l = SAMPLE_W'(ml);
      m.mix_r = SAMPLE_W'(mr);
      m.mono  = SAMPLE_W'((ml + mr) >>> 1);
      if (factive) begin
        fpos = (fpos + 1) & 18'h3FFFF;
        if (flen > 1 && fpos < flen - 1) begin
          idx  = 32'(longint'(fpos) * ENTRIES / (flen - 1));
          cv   = (idx < ENTRIES) ? curve[idx] : 65536;
          if (target) begin
            step = 32'((longint'(65536 - start_gain) * cv + 32768) >> 16);
            gain = start_gain + step;
          end else begin
            step = 32'((longint'(start_gain) * cv + 32768) >> 16);
            gain = start_gain - step;
          end
          if (gain > 65536) gain = 65536;
        end else begin
          gain    = target ? 65536 : 0;
          factive = 0;
          // release end: fade back to live clears the region
          if (target == 0) begin
            m.grain_rst = 1;
            fstart = 0; flength = 0;
            releases++;
          end
        end
      end
      if (live()) begin
        cap        = ring_cap();
        m.cap_wr   = 1;
        m.cap_addr = ADDR_W'(wptr);
        wptr       = (wptr + 1) % cap;
        if (wptr == 0) wraps++;
        filled     = (filled + 1 < cap) ? filled + 1 : cap;
      end
      m.reg_start = ADDR_W'(fstart);
      m.reg_len   = LEN_W'(flength);
      pending.push_back(m);
    endfunction

    task report(string what, longint got, longint want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
    endtask

    task check_result(mix_t r);
      mix_t e;
      if (pending.size() == 0) begin
        report("unexpected result beat", 1, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (r.mix_l !== e.mix_l)         report("mix_left", r.mix_l, e.mix_l);
      if (r.mix_r !== e.mix_r)         report("mix_right", r.mix_r, e.mix_r);
      if (r.mono !== e.mono)           report("mono_sum", r.mono, e.mono);
      if (r.cap_wr !== e.cap_wr)       report("capture_write", r.cap_wr, e.cap_wr);
      if (r.cap_addr !== e.cap_addr)   report("capture_address", r.cap_addr, e.cap_addr);
      if (r.reg_start !== e.reg_start) report("region_start", r.reg_start, e.reg_start);
      if (r.reg_len !== e.reg_len)     report("region_length", r.reg_len, e.reg_len);
      if (r.grain_rst !== e.grain_rst) report("grain_reset", r.grain_rst, e.grain_rst);
      if (r.render !== e.render)       report("render_enable", r.render, e.render);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_dry_left = '0, in_dry_right = '0;
  logic signed [SAMPLE_W-1:0] in_wet_left = '0, in_wet_right = '0;
  logic                       in_freeze_request = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_mix_left, out_mix_right, out_mono_sum;
  logic                       out_capture_write;
  logic [ADDR_W-1:0]          out_capture_address, out_region_start;
  logic [LEN_W-1:0]           out_region_length;
  logic                       out_grain_reset, out_render_enable;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_XFADE;
  logic [CFG_W-1:0]           cfg_data = '0;

  freeze_crossfade_controller i_dut (.*);

  freeze_scoreboard sb = new();
  bit quiet = 1'b0;   // set for the tail of the run: no gaps, no stalls

  // --------------------------------------------------------------------------
  // Result monitor: every accepted beat is checked against the oldest mix
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_mix_left, out_mix_right, out_mono_sum, out_capture_write,
                        out_capture_address, out_region_start, out_region_length,
                        out_grain_reset, out_render_enable});
  end

  // Receiver back-pressure in random runs, stalled about one run in three and open otherwise.
  initial begin
    @(posedge clk);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Hard stop if the block hangs.
  initial begin
    #20ms;
    $display("timeout with %0d mixes outstanding", sb.pending.size());
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return '0;
      3: return -24'sd1;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic send_frame(frame_t f);
    in_valid          <= 1'b1;
    in_dry_left       <= f.dry_l;
    in_dry_right      <= f.dry_r;
    in_wet_left       <= f.wet_l;
    in_wet_right      <= f.wet_r;
    in_freeze_request <= f.freeze;
    do @(posedge clk); while (in_stall);
    sb.note_frame(f);
    // sender gap burst; valid stays high across back-to-back beats
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Idle the sender until every mix has come back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int unsigned xf, int unsigned hd, int unsigned cs);
    write_reg(REG_XFADE, CFG_W'(xf));
    write_reg(REG_HOLD, CFG_W'(hd));
    write_reg(REG_CAPSIZE, CFG_W'(cs));
  endtask

  // Random frames with a freeze request held for runs, mostly long enough
  // for fades to finish, sometimes short to reverse a fade midway.
  task automatic random_frames(int n, int unsigned max_run);
    frame_t f;
    int     run;
    bit     req;
    req = $urandom_range(0, 1);
    run = 0;
    for (int i = 0; i < n; i++) begin
      if (run == 0) begin
        req = !req;
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                          : $urandom_range(1, max_run);
      end
      run--;
      f = '{pick_sample(), pick_sample(), pick_sample(), pick_sample(), req};
      if ($urandom_range(0, 29) == 0) f.freeze = $urandom_range(0, 1);
      send_frame(f);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed at reset settings: extremes while live, then a freeze with a
    // snapshot, a reversal mid-fade, and a refreeze that is not fully live.
    send_frame('{24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 1'b0});
    send_frame('{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 1'b0});
    send_frame('{-24'sd1, 24'sd0, 24'sd1, -24'sd1, 1'b0});
    send_frame('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1});
    send_frame('{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 1'b1});
    send_frame('{24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 1'b0});
    send_frame('{24'sd0, 24'sd0, 24'sh7FFFFF, 24'sh800000, 1'b1});
    send_frame('{24'sd1, -24'sd1, 24'sh800000, 24'sh7FFFFF, 1'b1});
    drain();

    // Zero registers act as one: one-sample fades, a one-slot ring.
    set_regs(0, 0, 0);
    send_frame('{24'sh7FFFFF, 24'sh800000, 24'sd5, -24'sd5, 1'b1});  // freeze still held, no snapshot
    send_frame('{24'sh123456, 24'sh654321, 24'sh7FFFFF, 24'sh800000, 1'b1});
    send_frame('{24'sh800000, 24'sh7FFFFF, 24'sd0, 24'sd0, 1'b0});   // release end
    send_frame('{24'sd3, 24'sd3, 24'sd3, 24'sd3, 1'b0});
    send_frame('{24'sd7, -24'sd7, 24'sd9, -24'sd9, 1'b1});          // snapshot, one-slot ring
    send_frame('{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0});
    drain();

    // Small ring that wraps, short hold.
    set_regs(8, 5, 16);
    random_frames(110, 30);
    drain();

    // One-sample fade, hold clamp to the fill, single-slot ring.
    set_regs(1, 20'hFFFFF, 1);
    random_frames(80, 10);
    drain();

    // Oversized ring setting, region clamped to fill.
    set_regs(30, 20, 20'hFFFFF);
    random_frames(120, 70);
    drain();

    // Shrink the ring below the pointers reached above.
    set_regs(17, 3, 7);
    random_frames(100, 40);
    drain();

    // Longest fades: gain moves slowly, mostly mid-fade reversals.
    set_regs(18'h3FFFF, DEPTH, DEPTH);
    random_frames(40, 20);
    drain();
    set_regs(192000, 1, 100);
    random_frames(40, 20);
    drain();

    // Mid-sized fades, then a tail with no gaps or stalls.
    set_regs(5, 12, 40);
    random_frames(100, 25);
    quiet = 1'b1;
    random_frames(100, 25);
    idle_sender();

    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (150) @(posedge clk);

    $display("checked %0d mix beats: %0d snapshots, %0d releases, %0d ring wraps",
             sb.checked, sb.snapshots, sb.releases, sb.wraps);
    $display("register settings covered zero, minimum, maximum and oversized values");
    if (sb.fail_count == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
